@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/dmn_pkg.sv @@
// ----------------------------------------------------------------------------
// dmn_pkg
// Types and constants shared by the mutual exclusion node.
// ----------------------------------------------------------------------------
package dmn_pkg;

	localparam int ID_W      = 4;
	localparam int CNT_CFG_W = 5;
	localparam int TS_W      = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 5;

	typedef enum logic [1:0] {
		REQ_ENTER = 2'd0,
		REQ_EXIT  = 2'd1,
		REQ_REPLY = 2'd2,
		REQ_PEER  = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		MSG_REQUEST = 2'd0,
		MSG_REPLY   = 2'd1,
		MSG_GRANT   = 2'd2
	} msg_kind_t;

	typedef enum logic [2:0] {
		MX_IDLE = 3'b001,
		MX_WANT = 3'b010,
		MX_IN   = 3'b100
	} mx_state_t;

	localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd1;

	localparam logic [ID_W-1:0]      OWN_ID_RST     = 4'd0;
	localparam logic [CNT_CFG_W-1:0] NODE_COUNT_RST = 5'd2;

	// Controller to datapath.
	typedef struct packed {
		logic capture;  // latch the accepted item
		logic exec;     // apply the item to the protocol state
		logic step;     // advance the broadcast scan by one node
		logic in_scan;  // controller is in its scan state
	} dmn_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic out_free;   // output register can take a result this cycle
		logic exec_scan;  // the held item needs a broadcast scan
		logic bit_hit;    // current scan node gets a message
		logic scan_last;  // that message is the final one
		logic work_any;   // scan work remains
	} dmn_sts_t;

endpackage

@@ design/dmn_if.sv @@
// ----------------------------------------------------------------------------
// dmn_if
// Handshake channels of the mutual exclusion node: input items, result
// items and configuration writes.
// ----------------------------------------------------------------------------
interface dmn_req_if import dmn_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [1:0]      req_type;
	logic [ID_W-1:0] peer_id;
	logic [TS_W-1:0] peer_timestamp;

	modport source (output valid, req_type, peer_id, peer_timestamp, input ready);
	modport sink   (input valid, req_type, peer_id, peer_timestamp, output ready);
endinterface

interface dmn_msg_if import dmn_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [1:0]      msg_kind;
	logic [ID_W-1:0] dest_id;
	logic [TS_W-1:0] msg_timestamp;
	logic            last;

	modport source (output valid, msg_kind, dest_id, msg_timestamp, last, input ready);
	modport sink   (input valid, msg_kind, dest_id, msg_timestamp, last, output ready);
endinterface

interface dmn_cfg_if import dmn_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ design/dmn_ctrl.sv @@
// ----------------------------------------------------------------------------
// dmn_ctrl
// Sequencer: accept an item, execute it once the output slot is free,
// then walk the broadcast scan when the item has messages for other nodes.
// ----------------------------------------------------------------------------
module dmn_ctrl import dmn_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  dmn_sts_t sts,
	output dmn_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_SCAN = 3'b100
	} ctrl_state_t;

	ctrl_state_t state_q, state_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		cmd         = '0;
		cmd.capture = req_valid && (state_q == S_IDLE);
		cmd.exec    = (state_q == S_EXEC) && sts.out_free;
		cmd.step    = (state_q == S_SCAN) && (!sts.bit_hit || sts.out_free);
		cmd.in_scan = (state_q == S_SCAN);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.capture) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (sts.out_free) state_d = sts.exec_scan ? S_SCAN : S_IDLE;
			end
			S_SCAN: begin
				if (sts.bit_hit && sts.out_free && sts.scan_last) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ design/dmn_dp.sv @@
// ----------------------------------------------------------------------------
// dmn_dp
// Protocol state, configuration registers, broadcast work mask and the
// output register of the mutual exclusion node.
// ----------------------------------------------------------------------------
module dmn_dp import dmn_pkg::*; #(
	parameter int MAX_NODES  = 16,
	parameter int CLOCK_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration writes
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	// input item payload
	input  logic [1:0]           req_type,
	input  logic [ID_W-1:0]      peer_id,
	input  logic [TS_W-1:0]      peer_timestamp,
	// result item
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           out_kind,
	output logic [ID_W-1:0]      out_dest,
	output logic [TS_W-1:0]      out_ts,
	output logic                 out_last,
	// sequencing
	input  dmn_cmd_t             cmd,
	output dmn_sts_t             sts
);

	localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int MW    = 1 << IDX_W;
	localparam int NW    = $clog2(MAX_NODES + 1);
	localparam int NCW   = (NW > CNT_CFG_W) ? NW : CNT_CFG_W;
	localparam int RW    = IDX_W;
	localparam int TW    = (CLOCK_BITS > TS_W) ? CLOCK_BITS : TS_W;
	localparam logic [TW-1:0] ClkMax  = TW'({CLOCK_BITS{1'b1}});
	localparam logic [RW-1:0] RcMax   = RW'(MAX_NODES - 1);
	localparam logic [NCW-1:0] NMax   = NCW'(MAX_NODES);

	// configuration
	logic [ID_W-1:0]      own_id_q;
	logic [CNT_CFG_W-1:0] node_count_q;

	// protocol state
	mx_state_t             mx_q;
	logic [CLOCK_BITS-1:0] clock_q;
	logic [CLOCK_BITS-1:0] rt_q;
	logic [RW-1:0]         rc_q;
	logic [MW-1:0]         defer_q;

	// held item and scan
	req_type_t       type_q;
	logic [ID_W-1:0] pid_q;
	logic [TS_W-1:0] pts_q;
	logic [MW-1:0]   work_q;
	logic [IDX_W-1:0] idx_q;

	// output register
	logic            out_valid_q;
	msg_kind_t       out_kind_q;
	logic [ID_W-1:0] out_dest_q;
	logic [TS_W-1:0] out_ts_q;
	logic            out_last_q;

	// --- derived terms ------------------------------------------------------
	logic [NCW-1:0] nc_ext, n_ext;
	logic           single_node, own_lt_n, pid_ok;
	logic [MW-1:0]  below_n, own_hot, top_hot, enter_mask, exit_mask, idx_hot;

	always_comb begin
		nc_ext = NCW'(node_count_q);
		priority if (nc_ext == '0)  n_ext = NCW'(1);
		else if (nc_ext > NMax)     n_ext = NMax;
		else                        n_ext = nc_ext;
	end

	assign single_node = (n_ext == NCW'(1));
	assign own_lt_n    = NCW'(own_id_q) < n_ext;
	assign pid_ok      = (pid_q != own_id_q) && (NCW'(pid_q) < n_ext);

	always_comb begin
		for (int i = 0; i < MW; i++) begin
			below_n[i] = (i < MAX_NODES) && (NCW'(i) < n_ext);
			own_hot[i] = (NCW'(i) == NCW'(own_id_q));
			top_hot[i] = (NCW'(i) == n_ext - NCW'(1));
		end
	end

	// Requests go to every other participant; with an id outside the
	// participants, drop the highest one so n-1 requests remain.
	assign enter_mask = own_lt_n ? (below_n & ~own_hot) : (below_n & ~top_hot);
	assign exit_mask  = defer_q & below_n & ~own_hot;

	// clock arithmetic
	logic [CLOCK_BITS-1:0] clk_inc, clk_merge;
	logic [TW-1:0]         pts_ext, pts_sat, rt_ext;

	assign clk_inc = (clock_q == {CLOCK_BITS{1'b1}}) ? clock_q : clock_q + 1'b1;
	assign pts_ext = TW'(pts_q);
	assign pts_sat = (pts_ext > ClkMax) ? ClkMax : pts_ext;
	assign clk_merge = (pts_sat > TW'(clock_q)) ? CLOCK_BITS'(pts_sat) : clock_q;
	assign rt_ext  = TW'(rt_q);

	// decisions on the held item
	logic          is_enter, is_exit, is_reply, is_peer;
	logic          enter_ok, reply_ok, reply_grant, answer, exec_emit;
	logic [RW-1:0] rc_inc;

	assign is_enter = (type_q == REQ_ENTER);
	assign is_exit  = (type_q == REQ_EXIT);
	assign is_reply = (type_q == REQ_REPLY);
	assign is_peer  = (type_q == REQ_PEER);

	assign enter_ok    = is_enter && (mx_q == MX_IDLE);
	assign reply_ok    = is_reply && (mx_q == MX_WANT);
	assign rc_inc      = (rc_q < RcMax) ? rc_q + 1'b1 : rc_q;
	assign reply_grant = reply_ok && (NCW'(rc_inc) >= n_ext - NCW'(1));

	always_comb begin
		unique case (mx_q)
			MX_IDLE: answer = 1'b1;
			MX_WANT: answer = (pts_ext < rt_ext) ||
				((pts_ext == rt_ext) && (pid_q < own_id_q));
			default: answer = 1'b0;
		endcase
	end

	assign exec_emit = (enter_ok && single_node) || reply_grant ||
		(is_peer && pid_ok && answer);

	// scan terms
	always_comb begin
		for (int i = 0; i < MW; i++) idx_hot[i] = (IDX_W'(i) == idx_q);
	end

	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.exec_scan = (enter_ok && !single_node) || (is_exit && (exit_mask != '0));
	assign sts.bit_hit   = |(work_q & idx_hot);
	assign sts.scan_last = ((work_q & ~idx_hot) == '0);
	assign sts.work_any  = (work_q != '0);

	// --- configuration ------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q     <= OWN_ID_RST;
			node_count_q <= NODE_COUNT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_OWN_ID:     own_id_q     <= cfg_data[ID_W-1:0];
				CFG_NODE_COUNT: node_count_q <= cfg_data[CNT_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// --- held item ----------------------------------------------------------
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			type_q <= req_type_t'(req_type);
			pid_q  <= peer_id;
			pts_q  <= peer_timestamp;
		end
	end

	// --- protocol state and scan --------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mx_q    <= MX_IDLE;
			clock_q <= '0;
			rt_q    <= '0;
			rc_q    <= '0;
			defer_q <= '0;
			work_q  <= '0;
			idx_q   <= '0;
		end else if (cmd.exec) begin
			idx_q <= '0;
			unique case (type_q)
				REQ_ENTER: begin
					if (enter_ok) begin
						clock_q <= clk_inc;
						rt_q    <= clk_inc;
						rc_q    <= '0;
						mx_q    <= single_node ? MX_IN : MX_WANT;
						work_q  <= enter_mask;
					end
				end
				REQ_EXIT: begin
					work_q  <= exit_mask;
					defer_q <= '0;
					mx_q    <= MX_IDLE;
				end
				REQ_REPLY: begin
					if (reply_ok) begin
						rc_q <= rc_inc;
						if (reply_grant) mx_q <= MX_IN;
					end
				end
				REQ_PEER: begin
					if (pid_ok) begin
						clock_q <= clk_merge;
						if (!answer) defer_q[IDX_W'(pid_q)] <= 1'b1;
					end
				end
				default: ;
			endcase
		end else if (cmd.step) begin
			idx_q <= idx_q + 1'b1;
			if (sts.bit_hit) work_q <= work_q & ~idx_hot;
		end
	end

	// --- output register ----------------------------------------------------
	logic scan_emit;
	assign scan_emit = cmd.step && sts.bit_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.exec && exec_emit) || scan_emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_emit) begin
			out_kind_q <= is_enter ? MSG_REQUEST : MSG_REPLY;
			out_dest_q <= ID_W'(idx_q);
			out_ts_q   <= is_enter ? rt_ext[TS_W-1:0] : '0;
			out_last_q <= sts.scan_last;
		end else if (cmd.exec && exec_emit) begin
			out_kind_q <= is_peer ? MSG_REPLY : MSG_GRANT;
			out_dest_q <= is_peer ? pid_q : '0;
			out_ts_q   <= '0;
			out_last_q <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_dest  = out_dest_q;
	assign out_ts    = out_ts_q;
	assign out_last  = out_last_q;

endmodule

@@ design/distributed_mutex_node.sv @@
// An item is captured in the idle state and executed in the exec state once
// the output register is free; at most one result is then registered there.
// Enter and exit walk node ids one per cycle, holding on a node that gets a
// message while the output register is full; items with none to send skip it.
// Reset (arst_n low) clears the protocol state, configuration and output
// valid at once; no clearing pass follows.
// ----------------------------------------------------------------------------
// distributed_mutex_node
// One node of Ricart-Agrawala mutual exclusion: keeps the Lamport clock,
// answers or defers peer requests, broadcasts requests on enter and releases
// deferred peers on exit. A sequencer drives a separate datapath.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module distributed_mutex_node import dmn_pkg::*; #(
	parameter int MAX_NODES  = 16,
	parameter int CLOCK_BITS = 32
) (
	input logic       clk,
	input logic       arst_n,
	dmn_cfg_if.sink   cfg,
	dmn_req_if.sink   req,
	dmn_msg_if.source msg
);

	dmn_cmd_t cmd;
	dmn_sts_t sts;

	// User writes configuration only while idle (unenforced); all taken.
	assign cfg.ready = 1'b1;

	// Sequencer: hold the input until the current item is fully delivered
	// into the output register, then reopen.
	dmn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: protocol state, broadcast mask, one-item output register that
	// lets a result wait while the next item is taken in.
	dmn_dp #(
		.MAX_NODES  (MAX_NODES),
		.CLOCK_BITS (CLOCK_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg.valid),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.req_type       (req.req_type),
		.peer_id        (req.peer_id),
		.peer_timestamp (req.peer_timestamp),
		.out_valid      (msg.valid),
		.out_ready      (msg.ready),
		.out_kind       (msg.msg_kind),
		.out_dest       (msg.dest_id),
		.out_ts         (msg.msg_timestamp),
		.out_last       (msg.last),
		.cmd            (cmd),
		.sts            (sts)
	);

	// A scan never runs with nothing left to send.
	`ASSERT_SAME(a_scan_has_work, cmd.in_scan, sts.work_any, "scan with empty work mask")

	// A scan message is only written when the output slot can take it.
	`ASSERT_SAME(a_emit_into_free, cmd.step && sts.bit_hit, sts.out_free, "result overwrites output")

	// After an item is accepted, the input closes until it is done.
	`ASSERT_NEXT(a_one_item, req.valid && req.ready, !req.ready, "input reopened too early")

	// A grant carries neither destination nor timestamp.
	`ASSERT_SAME(a_grant_clean, msg.valid && (msg.msg_kind == MSG_GRANT),
		(msg.dest_id == '0) && (msg.msg_timestamp == '0), "grant with payload")

endmodule

@@ dv/dmn_msg_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmn_msg_checker
// Watches the register writes, input items and outgoing messages of the
// mutual exclusion node, predicts every message and compares them in order.
// ----------------------------------------------------------------------------
module dmn_msg_checker import dmn_pkg::*; #(
	parameter int MAX_NODES = 16
) (
	input  logic clk,
	input  logic arst_n,
	dmn_cfg_if   cfg,
	dmn_req_if   req,
	dmn_msg_if   msg,
	output int   mismatches,
	output int   open_msgs,
	output int   msgs_checked,
	output int   grants_seen
);

	typedef struct packed {
		msg_kind_t       kind;
		logic [ID_W-1:0] dest;
		logic [TS_W-1:0] stamp;
		logic            last;
	} node_msg_t;

	// Protocol state and registers as the node should hold them.
	mx_state_t             node_state;
	logic [TS_W-1:0]       lamport;
	logic [TS_W-1:0]       request_stamp;
	int                    reply_tally;
	logic [MAX_NODES-1:0]  deferred;
	logic [ID_W-1:0]       own_id;
	logic [CNT_CFG_W-1:0]  node_count;

	node_msg_t expected_msgs[$];
	int        errs = 0;
	int        checked = 0;
	int        grants = 0;

	function automatic int active_nodes();
		if (node_count < 1)
			return 1;
		if (node_count > MAX_NODES)
			return MAX_NODES;
		return int'(node_count);
	endfunction

	task automatic predict_msgs(input req_type_t op, input logic [ID_W-1:0] pid,
			input logic [TS_W-1:0] pts);
		node_msg_t batch[$];
		int        n;
		int        i;
		bit        answer;
		n = active_nodes();
		case (op)
		REQ_ENTER: begin
			if (node_state == MX_IDLE) begin
				if (lamport != '1)
					lamport++;
				request_stamp = lamport;
				reply_tally   = 0;
				node_state    = MX_WANT;
				for (i = 0; i < n && batch.size() < n - 1; i++) begin
					if (i != own_id)
						batch.push_back(node_msg_t'{MSG_REQUEST, ID_W'(i), request_stamp, 1'b0});
				end
				if (n == 1) begin
					node_state = MX_IN;
					batch.push_back(node_msg_t'{MSG_GRANT, '0, '0, 1'b0});
				end
			end
		end
		REQ_EXIT: begin
			for (i = 0; i < n; i++) begin
				if (i != own_id && deferred[i])
					batch.push_back(node_msg_t'{MSG_REPLY, ID_W'(i), '0, 1'b0});
			end
			deferred   = '0;
			node_state = MX_IDLE;
		end
		REQ_REPLY: begin
			if (node_state == MX_WANT) begin
				if (reply_tally < MAX_NODES - 1)
					reply_tally++;
				if (reply_tally >= n - 1) begin
					node_state = MX_IN;
					batch.push_back(node_msg_t'{MSG_GRANT, '0, '0, 1'b0});
				end
			end
		end
		default: begin
			// peer request: own id and ids outside the group are dropped
			if (pid != own_id && pid < n) begin
				case (node_state)
				MX_IDLE: answer = 1'b1;
				MX_WANT: answer = (pts < request_stamp) ||
						(pts == request_stamp && pid < own_id);
				default: answer = 1'b0;
				endcase
				if (answer)
					batch.push_back(node_msg_t'{MSG_REPLY, pid, '0, 1'b0});
				else
					deferred[pid] = 1'b1;
				if (pts > lamport)
					lamport = pts;
			end
		end
		endcase
		if (batch.size() != 0)
			batch[batch.size() - 1].last = 1'b1;
		foreach (batch[j])
			expected_msgs.push_back(batch[j]);
	endtask

	task automatic compare_msg();
		node_msg_t want;
		if (expected_msgs.size() == 0) begin
			errs++;
			$error("unexpected message: msg_kind %0d dest_id %0d", msg.msg_kind, msg.dest_id);
		end else begin
			want = expected_msgs.pop_front();
			checked++;
			if (want.kind == MSG_GRANT)
				grants++;
			if (msg.msg_kind !== want.kind) begin
				errs++;
				$error("msg_kind: expected %0d, got %0d", want.kind, msg.msg_kind);
			end
			if (msg.dest_id !== want.dest) begin
				errs++;
				$error("dest_id: expected %0d, got %0d", want.dest, msg.dest_id);
			end
			if (msg.msg_timestamp !== want.stamp) begin
				errs++;
				$error("msg_timestamp: expected %0h, got %0h", want.stamp, msg.msg_timestamp);
			end
			if (msg.last !== want.last) begin
				errs++;
				$error("last: expected %0d, got %0d", want.last, msg.last);
			end
		end
	endtask

	// Results first: a message leaving at this edge never belongs to an item
	// taken at the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_state    = MX_IDLE;
			lamport       = '0;
			request_stamp = '0;
			reply_tally   = 0;
			deferred      = '0;
			own_id        = OWN_ID_RST;
			node_count    = NODE_COUNT_RST;
			expected_msgs.delete();
			mismatches   <= 0;
			open_msgs    <= 0;
			msgs_checked <= 0;
			grants_seen  <= 0;
		end else begin
			if (msg.valid && msg.ready)
				compare_msg();
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
				CFG_OWN_ID:     own_id = cfg.data[ID_W-1:0];
				CFG_NODE_COUNT: node_count = cfg.data;
				default: ;
				endcase
			end
			if (req.valid && req.ready)
				predict_msgs(req_type_t'(req.req_type), req.peer_id, req.peer_timestamp);
			mismatches   <= errs;
			open_msgs    <= expected_msgs.size();
			msgs_checked <= checked;
			grants_seen  <= grants;
		end
	end

endmodule

@@ dv/tb_distributed_mutex_node.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_distributed_mutex_node
// Drives the mutual exclusion node with directed protocol cases and random
// enter/request/reply/exit sessions under several group settings, with
// random stalls on both channels; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_distributed_mutex_node;
	import dmn_pkg::*;

	localparam int RANDOM_ITEMS    = 330;
	localparam int HOLD_OFF_CYCLES = 300;   // long output stall to back up the node
	localparam int SETTLE_CYCLES   = 24;    // a full scan of 16 nodes plus margin
	localparam int WATCHDOG_LIMIT  = 2000;  // cycles without any handshake

	logic clk;
	logic arst_n;

	dmn_cfg_if cfg_ch ();
	dmn_req_if req_ch ();
	dmn_msg_if msg_ch ();

	distributed_mutex_node dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.msg    (msg_ch)
	);

	int mismatches;
	int open_msgs;
	int msgs_checked;
	int grants_seen;

	dmn_msg_checker u_msg_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_ch),
		.req          (req_ch),
		.msg          (msg_ch),
		.mismatches   (mismatches),
		.open_msgs    (open_msgs),
		.msgs_checked (msgs_checked),
		.grants_seen  (grants_seen)
	);

	// Knobs shared between the sender and the receiver process.
	bit idle_en = 1'b1;
	int hold_off_reqs = 0;

	// Sender-side bookkeeping: group settings and a rough idea of the node's
	// clock, so peer times land near it and hit ties and near misses.
	logic [ID_W-1:0] own_cfg = OWN_ID_RST;
	int              nodes_cfg = 2;
	logic [TS_W-1:0] stamp_hint = '0;
	int              items_sent = 0;
	int              cfg_writes = 0;
	int              quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Offer one item, optionally after an idle burst, and hold it until taken.
	// Valid stays high on return so back-to-back items never drop it.
	task automatic send_item(input req_type_t op, input logic [ID_W-1:0] pid,
			input logic [TS_W-1:0] ts);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.req_type       <= op;
		req_ch.peer_id        <= pid;
		req_ch.peer_timestamp <= ts;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
		if (op == REQ_PEER && ts > stamp_hint)
			stamp_hint = ts;
		if (op == REQ_ENTER && stamp_hint != '1)
			stamp_hint++;
	endtask

	// Non-peer items ignore id and time; fill them with noise anyway.
	task automatic send_op(input req_type_t op);
		send_item(op, ID_W'($urandom_range(0, 15)), $urandom());
	endtask

	// Mostly near the node's clock, now and then zero or anywhere.
	function automatic logic [TS_W-1:0] peer_stamp();
		int          pick;
		logic [32:0] t;
		pick = $urandom_range(0, 99);
		if (pick < 4)
			return $urandom();
		if (pick < 6)
			return '0;
		t = {1'b0, stamp_hint} + 33'($urandom_range(0, 6));
		t = (t < 3) ? 33'd0 : t - 33'd3;
		if (t > 33'hFFFF_FFFF)
			t = 33'hFFFF_FFFF;
		return t[TS_W-1:0];
	endfunction

	// Peer requests mostly from group members, sometimes from our own id or
	// from outside the group.
	task automatic send_peer();
		int              pick;
		logic [ID_W-1:0] pid;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			pid = own_cfg;
		else if (pick == 1)
			pid = ID_W'($urandom_range(0, 15));
		else
			pid = ID_W'($urandom_range(0, nodes_cfg - 1));
		send_item(REQ_PEER, pid, peer_stamp());
	endtask

	// Write both registers back to back, then drop valid.
	task automatic set_config(input logic [ID_W-1:0] own, input logic [CNT_CFG_W-1:0] count);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= CFG_OWN_ID;
		cfg_ch.data  <= CNT_CFG_W'(own);
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.index <= CFG_NODE_COUNT;
		cfg_ch.data  <= count;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		cfg_writes += 2;
		own_cfg = own;
		nodes_cfg = (count < 1) ? 1 : (count > 16) ? 16 : int'(count);
	endtask

	// Drain every expected message, then give a silent item (ignored enter,
	// deferred request) time to finish.
	task automatic settle();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (open_msgs != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One round of the protocol with random content: enter, peer traffic,
	// replies (usually the full count), more peers, exit. Some rounds break
	// the pattern: short or long on replies, stray items, no exit.
	task automatic run_session();
		int replies;
		send_op(REQ_ENTER);
		repeat ($urandom_range(0, 2)) send_peer();
		replies = ($urandom_range(0, 4) == 0) ? $urandom_range(0, nodes_cfg) : nodes_cfg - 1;
		repeat (replies) begin
			send_op(REQ_REPLY);
			if ($urandom_range(0, 3) == 0)
				send_peer();
		end
		repeat ($urandom_range(0, 3)) send_peer();
		if ($urandom_range(0, 5) == 0)
			send_item(req_type_t'($urandom_range(0, 3)), ID_W'($urandom_range(0, 15)),
					$urandom());
		if ($urandom_range(0, 7) != 0)
			send_op(REQ_EXIT);
	endtask

	// Receiver: ready in random runs, random stall bursts, and one long
	// hold-off on request from the stimulus.
	initial begin
		int holds_done;
		holds_done = 0;
		msg_ch.ready <= 1'b0;
		forever begin
			if (hold_off_reqs != holds_done) begin
				holds_done++;
				msg_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else if (idle_en && $urandom_range(0, 3) == 0) begin
				msg_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				msg_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// Watchdog: any handshake on any channel counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (msg_ch.valid && msg_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$error("no handshake for %0d cycles, %0d messages outstanding",
					quiet_cycles, open_msgs);
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int                   phase;
		int                   item_goal;
		logic [CNT_CFG_W-1:0] count;

		arst_n                <= 1'b0;
		cfg_ch.valid          <= 1'b0;
		cfg_ch.index          <= CFG_OWN_ID;
		cfg_ch.data           <= '0;
		req_ch.valid          <= 1'b0;
		req_ch.req_type       <= REQ_ENTER;
		req_ch.peer_id        <= '0;
		req_ch.peer_timestamp <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings (own id 0, two nodes). Request from idle is answered,
		// stray reply and exit do nothing, repeated enter is ignored, a tie from
		// a higher id is deferred, own id and out-of-group ids are dropped
		// without moving the clock, a request while inside is deferred.
		send_item(REQ_PEER, 4'd1, 32'd0);
		send_op(REQ_REPLY);
		send_op(REQ_EXIT);
		send_op(REQ_ENTER);
		send_op(REQ_ENTER);
		send_item(REQ_PEER, 4'd1, 32'd1);
		send_item(REQ_PEER, 4'd0, 32'd5);
		send_item(REQ_PEER, 4'd2, 32'd0);
		send_op(REQ_REPLY);
		send_op(REQ_REPLY);
		send_item(REQ_PEER, 4'd1, 32'd0);
		send_op(REQ_EXIT);
		settle();

		// Full group of 16 with our id on top: 15 requests, ties from lower
		// ids win, a later request is deferred and released on exit.
		set_config(4'd15, 5'd16);
		send_op(REQ_ENTER);
		send_item(REQ_PEER, 4'd3, 32'd2);
		send_item(REQ_PEER, 4'd7, 32'd3);
		send_item(REQ_PEER, 4'd0, 32'd1);
		send_item(REQ_PEER, 4'd14, 32'd2);
		send_op(REQ_EXIT);
		settle();

		// Count of zero acts as a single node: enter grants at once.
		set_config(4'd3, 5'd0);
		send_op(REQ_ENTER);
		send_item(REQ_PEER, 4'd0, 32'd9);
		send_op(REQ_REPLY);
		send_op(REQ_EXIT);
		settle();

		// Our id outside a group of four: requests to 0..2, grant on the
		// third reply, a request while inside waits for exit.
		set_config(4'd12, 5'd4);
		send_op(REQ_ENTER);
		repeat (3) send_op(REQ_REPLY);
		send_item(REQ_PEER, 4'd2, 32'd0);
		send_op(REQ_EXIT);
		settle();

		// Random phases: new settings each phase, extremes first, then mostly
		// small groups to keep scans short.
		item_goal = items_sent + RANDOM_ITEMS;
		phase = 0;
		while (items_sent < item_goal) begin
			case (phase)
			0:       count = 5'd16;
			1:       count = 5'd1;
			2:       count = 5'd0;
			3:       count = 5'd31;
			4:       count = 5'd17;
			default: count = ($urandom_range(0, 9) < 7) ? CNT_CFG_W'($urandom_range(2, 5)) :
					CNT_CFG_W'($urandom_range(6, 16));
			endcase
			set_config(ID_W'($urandom_range(0, 15)), count);
			// Stall the receiver while a 16-node broadcast is offered.
			if (phase == 0)
				hold_off_reqs <= hold_off_reqs + 1;
			// Run the tail with both sides at full rate.
			if (items_sent >= item_goal - 70)
				idle_en <= 1'b0;
			repeat (4) run_session();
			settle();
			phase++;
		end

		// Clock saturation, kept to the end so it doesn't pin the clock for the
		// random part: a peer at the top time, enter at the top, then a smaller
		// time wins, a tie from a higher id is deferred, one from a lower id wins.
		set_config(4'd5, 5'd31);
		send_op(REQ_EXIT);
		send_item(REQ_PEER, 4'd1, '1);
		send_op(REQ_ENTER);
		send_item(REQ_PEER, 4'd2, 32'hFFFF_FFFE);
		send_item(REQ_PEER, 4'd9, '1);
		send_item(REQ_PEER, 4'd1, '1);
		send_op(REQ_EXIT);
		settle();

		$display("Sent %0d items and %0d register writes across %0d group settings,",
				items_sent, cfg_writes, phase + 5);
		$display("with a long output stall and clock saturation; %0d messages, %0d grants.",
				msgs_checked, grants_seen);
		if (open_msgs != 0)
			$error("%0d expected messages never arrived", open_msgs);
		if (mismatches == 0 && open_msgs == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
